// ===== src/imu_body_accel_compensation_core_defines.svh =====
// ---------------------------------------------------------------------------
// IMU body acceleration compensation - assertion macros
// Shared concurrent assertion wrappers clocked on clk_i.
// ---------------------------------------------------------------------------
`ifndef IMU_BODY_ACCEL_COMPENSATION_CORE_DEFINES_SVH
`define IMU_BODY_ACCEL_COMPENSATION_CORE_DEFINES_SVH

// Assertion that is switched off while rst_ni is low.
`define IBAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assertion that must hold at every edge, reset included.
`define IBAC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/ibac_pkg.sv =====
// ---------------------------------------------------------------------------
// IMU body acceleration compensation - package
// Widths, register codes, micro-operation table and shared types.
// ---------------------------------------------------------------------------
package ibac_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QUAT_FRAC = 14;

  localparam int GYRO_W  = 24;
  localparam int ACCEL_W = 25;
  localparam int QUAT_W  = 16;
  localparam int LEVER_W = 18;
  localparam int GRAV_W  = 20;
  localparam int RATE_W  = 10;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 20;

  localparam int IN_DATA_W  = 216;
  localparam int OUT_DATA_W = 80;

  // Internal value widths.
  localparam int DIFF_W  = GYRO_W + 1;
  localparam int MAT_W   = 2 * QUAT_W + 2;
  localparam int WSUM_W  = 2 * GYRO_W - FRAC_BITS + 1;
  localparam int WPROD_W = 2 * GYRO_W - FRAC_BITS;
  localparam int ALPHA_W = DIFF_W + RATE_W;
  localparam int ACC_W   = 40;
  localparam int OPA_W   = ALPHA_W;
  localparam int OPB_W   = ACCEL_W;
  localparam int PROD_W  = OPA_W + OPB_W;

  localparam int NUM_STEPS = 20;
  localparam int STEP_W    = $clog2(NUM_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_LEVER   = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_GRAVITY = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_RATE    = CFG_ADDR_W'(2);

  localparam logic [GRAV_W-1:0] GRAVITY_RST = GRAV_W'(((49 << FRAC_BITS) + 2) / 5);
  localparam logic [RATE_W-1:0] RATE_RST    = RATE_W'(50);

  typedef logic signed [GYRO_W-1:0]  gyro_t;
  typedef logic signed [ACCEL_W-1:0] accel_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [MAT_W-1:0]   mat_t;
  typedef logic signed [WSUM_W-1:0]  wsum_t;
  typedef logic signed [WPROD_W-1:0] wprod_t;
  typedef logic signed [ALPHA_W-1:0] alpha_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [OPA_W-1:0]   opa_t;
  typedef logic signed [OPB_W-1:0]   opb_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  localparam mat_t  M2_INIT   = mat_t'(64'sd1 <<< (2 * QUAT_FRAC));
  localparam prod_t RND_FRAC  = prod_t'(64'sd1 <<< (FRAC_BITS - 1));
  localparam prod_t RND_QUAT  = prod_t'(64'sd1 <<< (2 * QUAT_FRAC - 1));
  localparam acc_t  SAT_HI    = acc_t'((64'sd1 <<< (ACCEL_W - 1)) - 64'sd1);
  localparam acc_t  SAT_LO    = acc_t'(-(64'sd1 <<< (ACCEL_W - 1)));

  typedef struct packed {
    logic [4:0] pad;
    quat_t      quat_w;
    quat_t      quat_z;
    quat_t      quat_y;
    quat_t      quat_x;
    accel_t     accel_raw_z;
    accel_t     accel_raw_y;
    accel_t     accel_raw_x;
    gyro_t      gyro_z;
    gyro_t      gyro_y;
    gyro_t      gyro_x;
  } in_pkt_t;

  typedef struct packed {
    logic [4:0] pad;
    accel_t     accel_body_z;
    accel_t     accel_body_y;
    accel_t     accel_body_x;
  } out_pkt_t;

  typedef enum logic [3:0] {
    A_QX, A_QY, A_QW, A_WX, A_WY, A_WZ, A_M0, A_M1,
    A_M2, A_DY, A_DZ, A_WSUM, A_WXY, A_WXZ, A_ALY, A_ALZ
  } opa_sel_e;

  typedef enum logic [2:0] {
    B_QX, B_QY, B_QZ, B_WY, B_WZ, B_GRAV, B_RATE, B_LEVER
  } opb_sel_e;

  typedef enum logic [1:0] {
    SH_X2, SH_R16, SH_R28, SH_NONE
  } shift_e;

  typedef enum logic [1:0] {
    OP_LOAD, OP_ADD, OP_SUB
  } wb_op_e;

  typedef enum logic [3:0] {
    D_M0, D_M1, D_M2, D_WSUM, D_WXY, D_WXZ, D_ALY, D_ALZ, D_B0, D_B1, D_B2
  } dst_e;

  typedef struct packed {
    opa_sel_e a_sel;
    opb_sel_e b_sel;
    shift_e   shift;
    wb_op_e   op;
    dst_e     dst;
  } uop_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic load_out;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // One multiply per step; the product is registered and written back in the
  // following step, so a consumer sits at least two steps behind its producer.
  function automatic uop_t uop_f(input logic [STEP_W-1:0] step);
    uop_t u;
    case (int'(step))
      0:       u = '{A_QX,   B_QZ,    SH_X2,   OP_ADD,  D_M0};
      1:       u = '{A_QY,   B_QZ,    SH_X2,   OP_ADD,  D_M1};
      2:       u = '{A_QX,   B_QX,    SH_X2,   OP_SUB,  D_M2};
      3:       u = '{A_QW,   B_QY,    SH_X2,   OP_SUB,  D_M0};
      4:       u = '{A_QW,   B_QX,    SH_X2,   OP_ADD,  D_M1};
      5:       u = '{A_QY,   B_QY,    SH_X2,   OP_SUB,  D_M2};
      6:       u = '{A_WY,   B_WY,    SH_R16,  OP_ADD,  D_WSUM};
      7:       u = '{A_M0,   B_GRAV,  SH_R28,  OP_SUB,  D_B0};
      8:       u = '{A_WZ,   B_WZ,    SH_R16,  OP_ADD,  D_WSUM};
      9:       u = '{A_M1,   B_GRAV,  SH_R28,  OP_SUB,  D_B1};
      10:      u = '{A_WX,   B_WY,    SH_R16,  OP_LOAD, D_WXY};
      11:      u = '{A_M2,   B_GRAV,  SH_R28,  OP_SUB,  D_B2};
      12:      u = '{A_WX,   B_WZ,    SH_R16,  OP_LOAD, D_WXZ};
      13:      u = '{A_DZ,   B_RATE,  SH_NONE, OP_LOAD, D_ALZ};
      14:      u = '{A_DY,   B_RATE,  SH_NONE, OP_LOAD, D_ALY};
      15:      u = '{A_WSUM, B_LEVER, SH_R16,  OP_ADD,  D_B0};
      16:      u = '{A_WXY,  B_LEVER, SH_R16,  OP_SUB,  D_B1};
      17:      u = '{A_ALZ,  B_LEVER, SH_R16,  OP_SUB,  D_B1};
      18:      u = '{A_WXZ,  B_LEVER, SH_R16,  OP_SUB,  D_B2};
      19:      u = '{A_ALY,  B_LEVER, SH_R16,  OP_ADD,  D_B2};
      default: u = '{A_QX,   B_QX,    SH_NONE, OP_LOAD, D_WXY};
    endcase
    return u;
  endfunction

endpackage

// ===== src/ibac_ctrl.sv =====
// ---------------------------------------------------------------------------
// IMU body acceleration compensation - controller
// One-hot sequencer that steps the shared multiplier through the step table.
// ---------------------------------------------------------------------------
`include "imu_body_accel_compensation_core_defines.svh"

module ibac_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  ibac_pkg::status_t status_i,
  output ibac_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WB   = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  logic [ibac_pkg::STEP_W-1:0]   cnt_q, cnt_d;

  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    cmd_o.start      = 1'b0;
    cmd_o.issue      = 1'b0;
    cmd_o.load_out   = 1'b0;
    cmd_o.uop        = ibac_pkg::uop_f(cnt_q);
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.start = 1'b1;
          cnt_d       = '0;
          state_d     = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.issue = 1'b1;
        if (cnt_q == ibac_pkg::LAST_STEP) begin
          state_d = S_WB;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_WB: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign s_tready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `IBAC_ASSERT(a_start_enters_run, cmd_o.start |=> (state_q == S_RUN) && (cnt_q == '0), "item accepted but sequence did not start at step zero")
  `IBAC_ASSERT(a_last_step_drains, (state_q == S_RUN) && (cnt_q == ibac_pkg::LAST_STEP) |=> (state_q == S_WB), "sequence did not leave run after its last step")

endmodule

// ===== src/ibac_datapath.sv =====
// ---------------------------------------------------------------------------
// IMU body acceleration compensation - datapath
// Config registers, operand muxes, shared multiplier, write-back and output.
// ---------------------------------------------------------------------------
`include "imu_body_accel_compensation_core_defines.svh"

module ibac_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [ibac_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [ibac_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [ibac_pkg::IN_DATA_W-1:0]    s_tdata_i,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [ibac_pkg::OUT_DATA_W-1:0]   m_tdata_o,
  output logic                              m_tuser_o,
  input  ibac_pkg::cmd_t                    cmd_i,
  output ibac_pkg::status_t                 status_o
);

  logic [ibac_pkg::LEVER_W-1:0] lever_q;
  logic [ibac_pkg::GRAV_W-1:0]  gravity_q;
  logic [ibac_pkg::RATE_W-1:0]  rate_q;

  ibac_pkg::in_pkt_t  in_pkt;
  ibac_pkg::gyro_t    prev_q [3];
  ibac_pkg::quat_t    qx_q, qy_q, qz_q, qw_q;
  ibac_pkg::diff_t    dy_q, dz_q;
  ibac_pkg::mat_t     m0_q, m1_q, m2_q;
  ibac_pkg::wsum_t    wsum_q;
  ibac_pkg::wprod_t   wxy_q, wxz_q;
  ibac_pkg::alpha_t   aly_q, alz_q;
  ibac_pkg::acc_t     b_q [3];

  ibac_pkg::opa_t     opa;
  ibac_pkg::opb_t     opb;
  ibac_pkg::prod_t    p_q;
  logic               wb_valid_q;
  ibac_pkg::shift_e   wb_shift_q;
  ibac_pkg::wb_op_e   wb_op_q;
  ibac_pkg::dst_e     wb_dst_q;
  ibac_pkg::acc_t     wb_val, wb_cur, wb_res;

  ibac_pkg::accel_t   sat_val [3];
  logic [2:0]         clip;
  ibac_pkg::out_pkt_t out_q;
  logic               sat_flag_q;
  logic               out_valid_q;

  assign in_pkt = ibac_pkg::in_pkt_t'(s_tdata_i);

  // Configuration registers; write them only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lever_q   <= '0;
      gravity_q <= ibac_pkg::GRAVITY_RST;
      rate_q    <= ibac_pkg::RATE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        ibac_pkg::CFG_LEVER:   lever_q   <= cfg_data_i[ibac_pkg::LEVER_W-1:0];
        ibac_pkg::CFG_GRAVITY: gravity_q <= cfg_data_i[ibac_pkg::GRAV_W-1:0];
        ibac_pkg::CFG_RATE:    rate_q    <= cfg_data_i[ibac_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // The previous gyro vector doubles as the current one once an item is
  // taken: the difference is formed at accept time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q[0] <= '0;
      prev_q[1] <= '0;
      prev_q[2] <= '0;
    end else if (cmd_i.start) begin
      prev_q[0] <= in_pkt.gyro_x;
      prev_q[1] <= in_pkt.gyro_y;
      prev_q[2] <= in_pkt.gyro_z;
    end
  end

  always_comb begin
    case (cmd_i.uop.a_sel)
      ibac_pkg::A_QX:   opa = ibac_pkg::opa_t'(qx_q);
      ibac_pkg::A_QY:   opa = ibac_pkg::opa_t'(qy_q);
      ibac_pkg::A_QW:   opa = ibac_pkg::opa_t'(qw_q);
      ibac_pkg::A_WX:   opa = ibac_pkg::opa_t'(prev_q[0]);
      ibac_pkg::A_WY:   opa = ibac_pkg::opa_t'(prev_q[1]);
      ibac_pkg::A_WZ:   opa = ibac_pkg::opa_t'(prev_q[2]);
      ibac_pkg::A_M0:   opa = ibac_pkg::opa_t'(m0_q);
      ibac_pkg::A_M1:   opa = ibac_pkg::opa_t'(m1_q);
      ibac_pkg::A_M2:   opa = ibac_pkg::opa_t'(m2_q);
      ibac_pkg::A_DY:   opa = ibac_pkg::opa_t'(dy_q);
      ibac_pkg::A_DZ:   opa = ibac_pkg::opa_t'(dz_q);
      ibac_pkg::A_WSUM: opa = ibac_pkg::opa_t'(wsum_q);
      ibac_pkg::A_WXY:  opa = ibac_pkg::opa_t'(wxy_q);
      ibac_pkg::A_WXZ:  opa = ibac_pkg::opa_t'(wxz_q);
      ibac_pkg::A_ALY:  opa = ibac_pkg::opa_t'(aly_q);
      ibac_pkg::A_ALZ:  opa = ibac_pkg::opa_t'(alz_q);
      default:          opa = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.uop.b_sel)
      ibac_pkg::B_QX:    opb = ibac_pkg::opb_t'(qx_q);
      ibac_pkg::B_QY:    opb = ibac_pkg::opb_t'(qy_q);
      ibac_pkg::B_QZ:    opb = ibac_pkg::opb_t'(qz_q);
      ibac_pkg::B_WY:    opb = ibac_pkg::opb_t'(prev_q[1]);
      ibac_pkg::B_WZ:    opb = ibac_pkg::opb_t'(prev_q[2]);
      ibac_pkg::B_GRAV:  opb = ibac_pkg::opb_t'(gravity_q);
      ibac_pkg::B_RATE:  opb = ibac_pkg::opb_t'(rate_q);
      ibac_pkg::B_LEVER: opb = ibac_pkg::opb_t'(lever_q);
      default:           opb = '0;
    endcase
  end

  // Scaling applied to the registered product before it is loaded or accumulated.
  always_comb begin
    case (wb_shift_q)
      ibac_pkg::SH_X2:   wb_val = ibac_pkg::acc_t'(p_q <<< 1);
      ibac_pkg::SH_R16:  wb_val = ibac_pkg::acc_t'((p_q + ibac_pkg::RND_FRAC)
                                                   >>> ibac_pkg::FRAC_BITS);
      ibac_pkg::SH_R28:  wb_val = ibac_pkg::acc_t'((p_q + ibac_pkg::RND_QUAT)
                                                   >>> (2 * ibac_pkg::QUAT_FRAC));
      ibac_pkg::SH_NONE: wb_val = ibac_pkg::acc_t'(p_q);
      default:           wb_val = '0;
    endcase
  end

  always_comb begin
    case (wb_dst_q)
      ibac_pkg::D_M0:   wb_cur = ibac_pkg::acc_t'(m0_q);
      ibac_pkg::D_M1:   wb_cur = ibac_pkg::acc_t'(m1_q);
      ibac_pkg::D_M2:   wb_cur = ibac_pkg::acc_t'(m2_q);
      ibac_pkg::D_WSUM: wb_cur = ibac_pkg::acc_t'(wsum_q);
      ibac_pkg::D_WXY:  wb_cur = ibac_pkg::acc_t'(wxy_q);
      ibac_pkg::D_WXZ:  wb_cur = ibac_pkg::acc_t'(wxz_q);
      ibac_pkg::D_ALY:  wb_cur = ibac_pkg::acc_t'(aly_q);
      ibac_pkg::D_ALZ:  wb_cur = ibac_pkg::acc_t'(alz_q);
      ibac_pkg::D_B0:   wb_cur = b_q[0];
      ibac_pkg::D_B1:   wb_cur = b_q[1];
      ibac_pkg::D_B2:   wb_cur = b_q[2];
      default:          wb_cur = '0;
    endcase
  end

  always_comb begin
    case (wb_op_q)
      ibac_pkg::OP_LOAD: wb_res = wb_val;
      ibac_pkg::OP_ADD:  wb_res = wb_cur + wb_val;
      ibac_pkg::OP_SUB:  wb_res = wb_cur - wb_val;
      default:           wb_res = wb_cur;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_valid_q <= 1'b0;
    end else begin
      wb_valid_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      p_q        <= opa * opb;
      wb_shift_q <= cmd_i.uop.shift;
      wb_op_q    <= cmd_i.uop.op;
      wb_dst_q   <= cmd_i.uop.dst;
    end
  end

  // Working registers: most are preloaded on accept, then loaded or accumulated step by step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      qx_q   <= in_pkt.quat_x;
      qy_q   <= in_pkt.quat_y;
      qz_q   <= in_pkt.quat_z;
      qw_q   <= in_pkt.quat_w;
      dy_q   <= ibac_pkg::diff_t'(in_pkt.gyro_y) - ibac_pkg::diff_t'(prev_q[1]);
      dz_q   <= ibac_pkg::diff_t'(in_pkt.gyro_z) - ibac_pkg::diff_t'(prev_q[2]);
      m0_q   <= '0;
      m1_q   <= '0;
      m2_q   <= ibac_pkg::M2_INIT;
      wsum_q <= '0;
      b_q[0] <= ibac_pkg::acc_t'(in_pkt.accel_raw_x);
      b_q[1] <= ibac_pkg::acc_t'(in_pkt.accel_raw_y);
      b_q[2] <= ibac_pkg::acc_t'(in_pkt.accel_raw_z);
    end else if (wb_valid_q) begin
      case (wb_dst_q)
        ibac_pkg::D_M0:   m0_q   <= ibac_pkg::mat_t'(wb_res);
        ibac_pkg::D_M1:   m1_q   <= ibac_pkg::mat_t'(wb_res);
        ibac_pkg::D_M2:   m2_q   <= ibac_pkg::mat_t'(wb_res);
        ibac_pkg::D_WSUM: wsum_q <= ibac_pkg::wsum_t'(wb_res);
        ibac_pkg::D_WXY:  wxy_q  <= ibac_pkg::wprod_t'(wb_res);
        ibac_pkg::D_WXZ:  wxz_q  <= ibac_pkg::wprod_t'(wb_res);
        ibac_pkg::D_ALY:  aly_q  <= ibac_pkg::alpha_t'(wb_res);
        ibac_pkg::D_ALZ:  alz_q  <= ibac_pkg::alpha_t'(wb_res);
        ibac_pkg::D_B0:   b_q[0] <= wb_res;
        ibac_pkg::D_B1:   b_q[1] <= wb_res;
        ibac_pkg::D_B2:   b_q[2] <= wb_res;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (b_q[k] > ibac_pkg::SAT_HI) begin
        sat_val[k] = ibac_pkg::accel_t'(ibac_pkg::SAT_HI);
        clip[k]    = 1'b1;
      end else if (b_q[k] < ibac_pkg::SAT_LO) begin
        sat_val[k] = ibac_pkg::accel_t'(ibac_pkg::SAT_LO);
        clip[k]    = 1'b1;
      end else begin
        sat_val[k] = ibac_pkg::accel_t'(b_q[k]);
        clip[k]    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.pad          <= '0;
      out_q.accel_body_x <= sat_val[0];
      out_q.accel_body_y <= sat_val[1];
      out_q.accel_body_z <= sat_val[2];
      sat_flag_q         <= |clip;
    end
  end

  assign status_o.out_free = !out_valid_q || m_tready_i;
  assign m_tvalid_o        = out_valid_q;
  assign m_tdata_o         = out_q;
  assign m_tuser_o         = sat_flag_q;

  `IBAC_ASSERT_ALWAYS(a_no_overwrite, (out_valid_q && !m_tready_i) |-> !cmd_i.load_out, "output register reloaded while a result was still waiting")

endmodule

// ===== src/imu_body_accel_compensation_core.sv =====
// ---------------------------------------------------------------------------
// IMU body acceleration compensation core
// Removes gravity and lever-arm terms from one IMU sample per transfer.
// ---------------------------------------------------------------------------
// Usage:
// An IMU sample (gyro rates, raw accelerometer vector, unit quaternion) is
// taken on the s_axis channel; one compensated body-frame acceleration
// vector leaves on the m_axis channel, with the clip flag in m_axis_tuser.
// Lever arm, gravity and sample rate are written through the cfg channel,
// which is always ready; write it only while no sample is in flight.
// One sample is processed at a time: after the input transfer it runs through
// the twenty steps on the single shared multiplier, a write-back state and a
// state that loads the output register once it is free, and only then returns
// to idle to accept the next transfer; m_axis_tvalid rises once it is loaded.
// The output register decouples the two sides: the next sample is accepted
// and computed while the previous result waits; if m_axis_tready is still
// low when the next result is ready, the sequencer holds until it drains.
// Reset clears the previous gyro vector to zero, restores default config
// (lever arm 0, gravity 9.8 m/s^2, 50 samples/s) and empties the output.
// ---------------------------------------------------------------------------
module imu_body_accel_compensation_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration writes: index 0 lever arm, 1 gravity, 2 sample rate.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ibac_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [ibac_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Sample input.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // gyro_x, gyro_y, gyro_z, accel_raw_x, accel_raw_y, accel_raw_z,
  // quat_x, quat_y, quat_z, quat_w, zero fill
  input  logic [ibac_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // Result output.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // accel_body_x, accel_body_y, accel_body_z, zero fill
  output logic [ibac_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // saturated
  output logic                             m_axis_tuser
);

  ibac_pkg::cmd_t    cmd;
  ibac_pkg::status_t status;

  // Config registers sit in the datapath and take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // The controller sequences the multiplier steps; the datapath holds the
  // operands, the accumulators and the output register.
  ibac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ibac_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
